// ----- sv/dsrf_pkg.sv -----
`default_nettype none

package dsrf_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int MAX_READ   = 64;

    localparam int PTR_W    = $clog2(RING_DEPTH);
    localparam int FILL_W   = (PTR_W + 1 > 10) ? PTR_W + 1 : 10;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 7;
    localparam int PHASE_W  = 9;
    localparam int STEP_W   = 11;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic push;
        logic flush;
        logic refuse;
        logic issue;
        logic issue_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic short_ring;
    } dp_status_t;

    function automatic logic [6:0] clamp_ratio(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0)
        begin
            r = 7'd1;
        end
        else if (v > 7'd64)
        begin
            r = 7'd64;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [3:0] clamp_channels(input logic [3:0] v);
        logic [3:0] r;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > 4'd8)
        begin
            r = 4'd8;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/dsrf_ram.sv -----
`default_nettype none

module dsrf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/dsrf_ctrl.sv -----
`default_nettype none

module dsrf_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [1:0]                op,
    input  wire logic [dsrf_pkg::LEN_W-1:0] read_len,
    input  wire dsrf_pkg::dp_status_t      status_in,
    output logic                           busy,
    output dsrf_pkg::ctrl_cmd_t            cmd
);

    import dsrf_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] count_next;
    logic             accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_READ && !status_in.short_ring)
                begin
                    state_next = ST_READ;
                    count_next = read_len;
                end
            end
            ST_READ:
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == LEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.push   = (op == OP_PUSH);
                    cmd.flush  = (op == OP_FLUSH);
                    cmd.refuse = (op == OP_READ) && status_in.short_ring;
                end
            end
            ST_READ:
            begin
                busy           = 1'b1;
                cmd.issue      = 1'b1;
                cmd.issue_last = (count_reg == LEN_W'(1));
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/dsrf_datapath.sv -----
`default_nettype none

module dsrf_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dsrf_pkg::ctrl_cmd_t           cmd,
    output dsrf_pkg::dp_status_t               status_out,
    input  wire logic                          cfg_write,
    input  wire logic [dsrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dsrf_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic signed [15:0]            sample_in,
    input  wire logic                          block_last,
    input  wire logic [dsrf_pkg::LEN_W-1:0]    read_len,
    output logic                               result_valid,
    output logic signed [15:0]                 sample_out,
    output logic                               last,
    output logic                               status,
    output logic [9:0]                         available,
    output logic [31:0]                        overflow_count
);

    import dsrf_pkg::*;

    logic [6:0]         ratio_reg;
    logic [3:0]         channels_reg;
    logic [2:0]         select_reg;

    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   rp_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               dropping_reg;
    logic [31:0]        ovf_reg;

    logic               valid_reg;
    logic               last_reg;
    logic               refused_reg;
    logic [9:0]         avail_reg;
    logic [31:0]        ovf_out_reg;

    logic [FILL_W-1:0]  fill;
    logic [FILL_W-1:0]  fill_after_read;
    logic [PTR_W-1:0]   wp_inc;
    logic [PTR_W-1:0]   rp_inc;
    logic [STEP_W-1:0]  step;
    logic [STEP_W-1:0]  phase_inc_w;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] phase_wrapped;
    logic               keep;
    logic               full;
    logic               ram_we;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign fill = (wp_reg >= rp_reg)
        ? FILL_W'(wp_reg) - FILL_W'(rp_reg)
        : FILL_W'(RING_DEPTH) - FILL_W'(rp_reg) + FILL_W'(wp_reg);
    assign fill_after_read = fill - 1'b1;

    assign wp_inc = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;

    assign status_out.short_ring = (read_len == '0)
        || (read_len > LEN_W'(MAX_READ))
        || (fill < FILL_W'(read_len));

    assign step        = STEP_W'(clamp_ratio(ratio_reg)) * STEP_W'(clamp_channels(channels_reg));
    assign phase_inc   = phase_reg + 1'b1;
    assign phase_inc_w = STEP_W'(phase_inc);

    always_comb
    begin
        phase_wrapped = phase_inc;
        if (STEP_W'(select_reg) < step)
        begin
            if (phase_inc_w == step)
            begin
                phase_wrapped = '0;
            end
        end
        else
        begin
            if (phase_inc_w == STEP_W'(select_reg) + step)
            begin
                phase_wrapped = PHASE_W'(select_reg);
            end
        end
    end

    assign keep   = !dropping_reg && (phase_reg == PHASE_W'(select_reg));
    assign full   = (wp_inc == rp_reg);
    assign ram_we = cmd.push && keep && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= 7'd24;
            channels_reg <= 4'd2;
            select_reg   <= 3'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RATIO:    ratio_reg    <= cfg_data;
                REG_CHANNELS: channels_reg <= cfg_data[3:0];
                REG_SELECT:   select_reg   <= cfg_data[2:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            phase_reg    <= '0;
            dropping_reg <= 1'b0;
            ovf_reg      <= '0;
        end
        else
        begin
            if (cmd.push)
            begin
                if (ram_we)
                begin
                    wp_reg <= wp_inc;
                end
                if (keep && full)
                begin
                    ovf_reg <= ovf_reg + 1'b1;
                end
                if (block_last)
                begin
                    phase_reg    <= '0;
                    dropping_reg <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_wrapped;
                    if (keep && full)
                    begin
                        dropping_reg <= 1'b1;
                    end
                end
            end
            if (cmd.flush)
            begin
                rp_reg <= wp_reg;
            end
            else if (cmd.issue)
            begin
                rp_reg <= rp_inc;
            end
        end
    end

    // result stage, aligned with the registered RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.issue || cmd.refuse;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            last_reg    <= cmd.issue_last;
            refused_reg <= 1'b0;
            avail_reg   <= fill_after_read[9:0];
            ovf_out_reg <= ovf_reg;
        end
        else if (cmd.refuse)
        begin
            last_reg    <= 1'b1;
            refused_reg <= 1'b1;
            avail_reg   <= fill[9:0];
            ovf_out_reg <= ovf_reg;
        end
    end

    dsrf_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sample_in),
        .re    (cmd.issue),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    assign result_valid   = valid_reg;
    assign sample_out     = refused_reg ? '0 : $signed(ram_rdata);
    assign last           = last_reg;
    assign status         = refused_reg;
    assign available      = avail_reg;
    assign overflow_count = ovf_out_reg;

endmodule

`default_nettype wire

// ----- sv/decimating_sample_ring_fifo.sv -----
// Push, flush and no-op items: no result; busy stays low. Read of N samples:
// busy while reading, one RAM read and one result per cycle, the first result
// after the state and RAM read registers; a refused read gives one result
// in the cycle after start. The receiver cannot stall: each result shows for
// one cycle with result_valid. Reset clears pointers, phase, drop flag and
// overflow count and restores the register defaults; ring contents undefined.
`default_nettype none

module decimating_sample_ring_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     op,
    input  wire logic signed [15:0]             sample_in,
    input  wire logic                           block_last,
    input  wire logic [dsrf_pkg::LEN_W-1:0]     read_len,
    input  wire logic                           cfg_write,
    input  wire logic [dsrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dsrf_pkg::CFG_W-1:0]     cfg_data,
    output logic                                result_valid,
    output logic signed [15:0]                  sample_out,
    output logic                                last,
    output logic                                status,
    output logic [9:0]                          available,
    output logic [31:0]                         overflow_count
);

    import dsrf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    dsrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .read_len  (read_len),
        .status_in (dp_status),
        .busy      (busy),
        .cmd       (cmd)
    );

    dsrf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status_out     (dp_status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_in      (sample_in),
        .block_last     (block_last),
        .read_len       (read_len),
        .result_valid   (result_valid),
        .sample_out     (sample_out),
        .last           (last),
        .status         (status),
        .available      (available),
        .overflow_count (overflow_count)
    );

endmodule

`default_nettype wire
